// ===== rtl/core/rpcf_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rpcf_pkg
// Shared types and constants of the RGB pixel color filter: mode codes,
// fixed-point luma and sepia weights, and the lane control struct.
// ============================================================================
package rpcf_pkg;

    localparam int ChanW  = 8;
    localparam int LumaW  = 24;   // 65535 * 255 fits in 24 bits
    localparam int WsumW  = 19;   // 1383 * 255 fits in 19 bits
    localparam int ProdW  = LumaW + WsumW;
    localparam int SepShift = 26;
    localparam int QuotW  = ProdW - SepShift;  // 17 bits
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 8;

    // Register indexes of the configuration port
    localparam logic [CfgIdxW-1:0] CFG_FILTER_MODE   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_ADJUST_AMOUNT = 2'd1;

    typedef enum logic [3:0] {
        MODE_INVERT     = 4'd0,
        MODE_BRIGHTEN   = 4'd1,
        MODE_DARKEN     = 4'd2,
        MODE_KEEP_BLUE  = 4'd3,
        MODE_KEEP_GREEN = 4'd4,
        MODE_KEEP_RED   = 4'd5,
        MODE_CLR_BLUE   = 4'd6,
        MODE_CLR_GREEN  = 4'd7,
        MODE_CLR_RED    = 4'd8,
        MODE_GRAY       = 4'd9,
        MODE_SEPIA      = 4'd10,
        MODE_WARM       = 4'd11
    } t_filter_mode;

    // Luma weights, 16 fraction bits
    localparam logic [LumaW-1:0] LUMA_WR = 24'd13926;
    localparam logic [LumaW-1:0] LUMA_WG = 24'd46884;
    localparam logic [LumaW-1:0] LUMA_WB = 24'd4725;
    localparam logic [LumaW-1:0] LUMA_RND = 24'd32768;

    // Sepia weights, 10 fraction bits: [output channel][r, g, b]
    // output channel 0 blue, 1 green, 2 red
    typedef logic [WsumW-1:0] t_wrow [3];
    localparam t_wrow SEPIA_W [3] = '{
        '{19'd279, 19'd547, 19'd134},
        '{19'd357, 19'd702, 19'd172},
        '{19'd402, 19'd787, 19'd194}
    };

    localparam logic [ChanW-1:0] WARM_SHIFT = 8'd20;
    localparam logic [ChanW-1:0] CHAN_MAX   = 8'd255;
    localparam logic [15:0]      SEP_SAT_LIM = 16'd65280;  // 255 * 256
    localparam logic [8:0]       RECIP_255  = 9'd257;      // 2^16 / 255, rounded down

    // Stage load enables handed to each sepia lane
    typedef struct packed {
        logic en2;
        logic en3;
    } t_lane_ctrl;

endpackage

// ===== rtl/core/rpcf_sepia_lane.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rpcf_sepia_lane
// One sepia output channel: luma times weighted sum, divide by 255 * 2^26,
// clamp to 255. Two register stages; the final correction is combinational.
// ============================================================================
module rpcf_sepia_lane
    import rpcf_pkg::*;
(
    input  logic               i_clk,
    input  t_lane_ctrl         i_ctrl,
    input  logic [LumaW-1:0]   i_luma,
    input  logic [WsumW-1:0]   i_wsum,
    output logic [ChanW-1:0]   o_sepia
);

    logic [ProdW-1:0]  n_prod;
    logic [QuotW-1:0]  r_x;
    logic              r_sat;
    logic [15:0]       r_x16;
    logic [ChanW-1:0]  r_q0;
    logic [24:0]       n_recip;
    logic [16:0]       n_rem;
    logic [ChanW-1:0]  n_q;

    assign n_prod = ProdW'(i_luma) * ProdW'(i_wsum);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en2) begin
            r_x <= n_prod[ProdW-1:SepShift];
        end
    end

    // approximate quotient by 257 / 2^16, at most one low
    assign n_recip = 25'(r_x[15:0]) * 25'(RECIP_255);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en3) begin
            r_sat <= (r_x >= QuotW'(SEP_SAT_LIM));
            r_x16 <= r_x[15:0];
            r_q0  <= n_recip[23:16];
        end
    end

    // correct the quotient with one compare and subtract
    assign n_rem = 17'(r_x16) - (17'(r_q0) * 17'd255);
    assign n_q   = (n_rem >= 17'd255) ? (r_q0 + 8'd1) : r_q0;
    assign o_sepia = r_sat ? CHAN_MAX : n_q;

endmodule

// ===== rtl/core/rgb_pixel_color_filter_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rgb_pixel_color_filter_core
// Per-pixel color filter for 24-bit BGR pixels, four-stage pipeline.
// ============================================================================
// Usage:
//   Input channel: i_in_valid with i_in_blue/green/red; the block drives
//   o_in_stall. A pixel transfers on a rising edge with valid high and stall
//   low. Output channel: o_out_valid with o_out_blue/green/red; the receiver
//   drives i_out_stall, and a result transfers on the same rule.
//   Configuration: i_cfg_we, i_cfg_index, i_cfg_data. Index 0 selects the
//   filter mode (low 4 bits), index 1 the brighten/darken step (8 bits);
//   other indexes are ignored. Write only while the pipeline is empty.
//   A pixel moves through stages 1 to 4 and shows from the stage 4 register.
//   Throughput: one pixel per clock without stalls; pipeline holds four pixels.
//   The depth is set by the sepia path: weighted sums, a 24x19 multiply,
//   a reciprocal multiply by 257, then the divide-by-255 correction.
//   Reset clears all stage valid bits and both registers to zero (invert).
//   When the receiver stalls, the last stage holds its result and earlier
//   stages keep filling bubbles; o_in_stall rises only once all four are full.
// ============================================================================
module rgb_pixel_color_filter_core
    import rpcf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    // input pixel channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [ChanW-1:0]    i_in_blue,
    input  logic [ChanW-1:0]    i_in_green,
    input  logic [ChanW-1:0]    i_in_red,
    // output pixel channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [ChanW-1:0]    o_out_blue,
    output logic [ChanW-1:0]    o_out_green,
    output logic [ChanW-1:0]    o_out_red
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [3:0]       r_mode;
    logic [ChanW-1:0] r_amount;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_INVERT;
            r_amount <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FILTER_MODE:   r_mode   <= i_cfg_data[3:0];
                CFG_ADJUST_AMOUNT: r_amount <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage enables: a stage loads when it is empty or the next one loads
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4;
    logic n_en1, n_en2, n_en3, n_en4;
    t_lane_ctrl n_lane_ctrl;

    assign n_en4 = !r_v4 || !i_out_stall;
    assign n_en3 = !r_v3 || n_en4;
    assign n_en2 = !r_v2 || n_en3;
    assign n_en1 = !r_v1 || n_en2;
    assign o_in_stall = !n_en1;

    assign n_lane_ctrl.en2 = n_en2;
    assign n_lane_ctrl.en3 = n_en3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (n_en1) r_v1 <= i_in_valid;
            if (n_en2) r_v2 <= r_v1;
            if (n_en3) r_v3 <= r_v2;
            if (n_en4) r_v4 <= r_v3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: point filters, luma accumulator, sepia weighted sums
    // ------------------------------------------------------------------
    logic [ChanW-1:0] n_pb, n_pg, n_pr;
    logic [ChanW:0]   n_add_b, n_add_g, n_add_r, n_warm_r;

    assign n_add_b  = {1'b0, i_in_blue}  + {1'b0, r_amount};
    assign n_add_g  = {1'b0, i_in_green} + {1'b0, r_amount};
    assign n_add_r  = {1'b0, i_in_red}   + {1'b0, r_amount};
    assign n_warm_r = {1'b0, i_in_red}   + {1'b0, WARM_SHIFT};

    always_comb begin
        n_pb = i_in_blue;
        n_pg = i_in_green;
        n_pr = i_in_red;
        unique case (r_mode)
            MODE_INVERT: begin
                n_pb = ~i_in_blue;
                n_pg = ~i_in_green;
                n_pr = ~i_in_red;
            end
            MODE_BRIGHTEN: begin
                n_pb = n_add_b[ChanW] ? CHAN_MAX : n_add_b[ChanW-1:0];
                n_pg = n_add_g[ChanW] ? CHAN_MAX : n_add_g[ChanW-1:0];
                n_pr = n_add_r[ChanW] ? CHAN_MAX : n_add_r[ChanW-1:0];
            end
            MODE_DARKEN: begin
                n_pb = (i_in_blue  > r_amount) ? (i_in_blue  - r_amount) : '0;
                n_pg = (i_in_green > r_amount) ? (i_in_green - r_amount) : '0;
                n_pr = (i_in_red   > r_amount) ? (i_in_red   - r_amount) : '0;
            end
            MODE_KEEP_BLUE: begin
                n_pg = '0;
                n_pr = '0;
            end
            MODE_KEEP_GREEN: begin
                n_pb = '0;
                n_pr = '0;
            end
            MODE_KEEP_RED: begin
                n_pb = '0;
                n_pg = '0;
            end
            MODE_CLR_BLUE:  n_pb = '0;
            MODE_CLR_GREEN: n_pg = '0;
            MODE_CLR_RED:   n_pr = '0;
            MODE_WARM: begin
                n_pr = n_warm_r[ChanW] ? CHAN_MAX : n_warm_r[ChanW-1:0];
                n_pb = (i_in_blue > WARM_SHIFT) ? (i_in_blue - WARM_SHIFT) : '0;
            end
            // gray and sepia are taken from their own paths; unused codes pass
            default: ;
        endcase
    end

    logic [LumaW-1:0] n_luma;
    logic [WsumW-1:0] n_wsum [3];

    assign n_luma = LUMA_WR * LumaW'(i_in_red)
                  + LUMA_WG * LumaW'(i_in_green)
                  + LUMA_WB * LumaW'(i_in_blue);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_wsum[k] = SEPIA_W[k][0] * WsumW'(i_in_red)
                      + SEPIA_W[k][1] * WsumW'(i_in_green)
                      + SEPIA_W[k][2] * WsumW'(i_in_blue);
        end
    end

    logic [LumaW-1:0] r_luma1;
    logic [WsumW-1:0] r_wsum1 [3];
    logic [ChanW-1:0] r_pix1 [3];

    always_ff @(posedge i_clk) begin
        if (n_en1) begin
            r_luma1    <= n_luma;
            r_wsum1[0] <= n_wsum[0];
            r_wsum1[1] <= n_wsum[1];
            r_wsum1[2] <= n_wsum[2];
            r_pix1[0]  <= n_pb;
            r_pix1[1]  <= n_pg;
            r_pix1[2]  <= n_pr;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: rounded gray level; sepia products inside the lanes
    // ------------------------------------------------------------------
    logic [LumaW-1:0] n_luma_rnd;
    logic [ChanW-1:0] r_gray2, r_gray3;
    logic [ChanW-1:0] r_pix2 [3];
    logic [ChanW-1:0] r_pix3 [3];

    assign n_luma_rnd = r_luma1 + LUMA_RND;

    always_ff @(posedge i_clk) begin
        if (n_en2) begin
            r_gray2 <= n_luma_rnd[LumaW-1:16];
            r_pix2  <= r_pix1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: carry point and gray results alongside the sepia divide
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (n_en3) begin
            r_gray3 <= r_gray2;
            r_pix3  <= r_pix2;
        end
    end

    logic [ChanW-1:0] n_sepia [3];

    for (genvar g = 0; g < 3; g++) begin : g_lane
        rpcf_sepia_lane u_lane (
            .i_clk   (i_clk),
            .i_ctrl  (n_lane_ctrl),
            .i_luma  (r_luma1),
            .i_wsum  (r_wsum1[g]),
            .o_sepia (n_sepia[g])
        );
    end

    // ------------------------------------------------------------------
    // Stage 4: select by mode into the output register; hold while stalled
    // ------------------------------------------------------------------
    logic [ChanW-1:0] n_ob, n_og, n_or;
    logic [ChanW-1:0] r_ob, r_og, r_or;

    always_comb begin
        priority if (r_mode == MODE_GRAY) begin
            n_ob = r_gray3;
            n_og = r_gray3;
            n_or = r_gray3;
        end else if (r_mode == MODE_SEPIA) begin
            n_ob = n_sepia[0];
            n_og = n_sepia[1];
            n_or = n_sepia[2];
        end else begin
            n_ob = r_pix3[0];
            n_og = r_pix3[1];
            n_or = r_pix3[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en4) begin
            r_ob <= n_ob;
            r_og <= n_og;
            r_or <= n_or;
        end
    end

    assign o_out_valid = r_v4;
    assign o_out_blue  = r_ob;
    assign o_out_green = r_og;
    assign o_out_red   = r_or;

endmodule
